FILE: rtl/core/dav_pkg.sv
// ---------------------------------------------------------------------------
// dav_pkg: shared types and constants for the volume button controller
// Transaction payloads, register indexes and reset values of the settings.
// ---------------------------------------------------------------------------
package dav_pkg;

  localparam int unsigned VOL_W     = 7;
  localparam int unsigned SETTLE_W  = 4;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_STEP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_FLOOR        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_CEILING      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD_TICKS = 3'd5;

  localparam logic [VOL_W-1:0]    RST_VOLUME_STEP         = 7'd5;
  localparam logic [VOL_W-1:0]    RST_VOLUME_FLOOR        = 7'd0;
  localparam logic [VOL_W-1:0]    RST_VOLUME_CEILING      = 7'd100;
  localparam logic [SETTLE_W-1:0] RST_SETTLE_SAMPLES      = 4'd3;
  localparam logic [TICK_W-1:0]   RST_LONG_PRESS_TICKS    = 8'd30;
  localparam logic [TICK_W-1:0]   RST_REPEAT_PERIOD_TICKS = 8'd10;

  localparam logic [TICK_W-1:0]   TICK_MAX = 8'd255;

  typedef struct packed {
    logic             up_level;
    logic             down_level;
    logic [VOL_W-1:0] current_volume;
  } item_t;

  typedef struct packed {
    logic [VOL_W-1:0] new_volume;
    logic             volume_write;
    logic             up_fired;
    logic             down_fired;
  } result_t;

  // timing settings shared by both button scanners
  typedef struct packed {
    logic [SETTLE_W-1:0] settle_samples;
    logic [TICK_W-1:0]   long_press_ticks;
    logic [TICK_W-1:0]   repeat_period_ticks;
  } scan_cfg_t;

endpackage

FILE: rtl/core/debounce_autorepeat_volume.sv
// ---------------------------------------------------------------------------
// debounce_autorepeat_volume: two-button volume control
// Debounces up and down buttons per scan tick, steps and clamps the volume.
// ---------------------------------------------------------------------------
//  channel | signals                         | direction | payload
//  item    | item_valid, item_stall, item    | in        | item_t, one scan tick
//  result  | result_valid, result_stall, result | out    | result_t, one per tick
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in | register write
//
//  One tick per clock unless stalled; the result is registered and appears in the cycle after its transaction.
//  The button state and step logic sit between the item port and the result
//  register, so a full result register that is stalled holds off new items.
//  Synchronous reset restores the register defaults and released buttons.
//  cfg_ready is always high.
module debounce_autorepeat_volume (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  dav_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output dav_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dav_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dav_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import dav_pkg::*;

  logic [VOL_W-1:0] volume_step;
  logic [VOL_W-1:0] volume_floor;
  logic [VOL_W-1:0] volume_ceiling;
  scan_cfg_t        scan_cfg;

  logic             accept;
  logic             up_fire;
  logic             down_fire;
  logic [VOL_W-1:0] after_up;
  logic [VOL_W-1:0] after_down;
  result_t          result_next;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_step                  <= RST_VOLUME_STEP;
      volume_floor                 <= RST_VOLUME_FLOOR;
      volume_ceiling               <= RST_VOLUME_CEILING;
      scan_cfg.settle_samples      <= RST_SETTLE_SAMPLES;
      scan_cfg.long_press_ticks    <= RST_LONG_PRESS_TICKS;
      scan_cfg.repeat_period_ticks <= RST_REPEAT_PERIOD_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VOLUME_STEP:         volume_step <= cfg_data[VOL_W-1:0];
        REG_VOLUME_FLOOR:        volume_floor <= cfg_data[VOL_W-1:0];
        REG_VOLUME_CEILING:      volume_ceiling <= cfg_data[VOL_W-1:0];
        REG_SETTLE_SAMPLES:      scan_cfg.settle_samples <= cfg_data[SETTLE_W-1:0];
        REG_LONG_PRESS_TICKS:    scan_cfg.long_press_ticks <= cfg_data[TICK_W-1:0];
        REG_REPEAT_PERIOD_TICKS: scan_cfg.repeat_period_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  dav_button u_up (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .level   (item.up_level),
    .cfg     (scan_cfg),
    .fire    (up_fire)
  );

  dav_button u_down (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .level   (item.down_level),
    .cfg     (scan_cfg),
    .fire    (down_fire)
  );

  // ceiling first, then floor, so the floor wins when they cross
  function automatic logic [VOL_W-1:0] step_volume(
    input logic [VOL_W-1:0] vol,
    input logic             up,
    input logic [VOL_W-1:0] step,
    input logic [VOL_W-1:0] lo,
    input logic [VOL_W-1:0] hi
  );
    logic signed [VOL_W+1:0] v;
    v = up ? $signed({2'b00, vol}) + $signed({2'b00, step})
           : $signed({2'b00, vol}) - $signed({2'b00, step});
    if (v > $signed({2'b00, hi})) v = $signed({2'b00, hi});
    if (v < $signed({2'b00, lo})) v = $signed({2'b00, lo});
    return v[VOL_W-1:0];
  endfunction

  always_comb begin
    after_up   = up_fire ? step_volume(item.current_volume, 1'b1, volume_step,
                                       volume_floor, volume_ceiling)
                         : item.current_volume;
    after_down = down_fire ? step_volume(after_up, 1'b0, volume_step,
                                         volume_floor, volume_ceiling)
                           : after_up;
    result_next.new_volume   = after_down;
    result_next.volume_write = up_fire || down_fire;
    result_next.up_fired     = up_fire;
    result_next.down_fired   = down_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/core/dav_button.sv
// ---------------------------------------------------------------------------
// dav_button: debounce and auto-repeat for one active-low button
// Holds the per-button sample, confirmed level and counters; flags a step.
// ---------------------------------------------------------------------------
module dav_button (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              level,
  input  dav_pkg::scan_cfg_t cfg,
  output logic              fire
);
  import dav_pkg::*;

  logic                previous_sample, previous_sample_next;
  logic                confirmed_level, confirmed_level_next;
  logic [SETTLE_W-1:0] settle_count, settle_count_next;
  logic [TICK_W-1:0]   hold_count, hold_count_next;
  logic [TICK_W-1:0]   repeat_count, repeat_count_next;

  logic [SETTLE_W-1:0] settle_inc;
  logic [TICK_W-1:0]   hold_inc;
  logic [TICK_W-1:0]   repeat_inc;

  always_comb begin
    previous_sample_next = previous_sample;
    confirmed_level_next = confirmed_level;
    settle_count_next    = settle_count;
    hold_count_next      = hold_count;
    repeat_count_next    = repeat_count;
    fire                 = 1'b0;
    settle_inc = settle_count + SETTLE_W'(1);
    hold_inc   = (hold_count < cfg.long_press_ticks) ? hold_count + TICK_W'(1) : hold_count;
    repeat_inc = (repeat_count < TICK_MAX) ? repeat_count + TICK_W'(1) : repeat_count;
    if (level != previous_sample) begin
      previous_sample_next = level;
      settle_count_next    = '0;
    end else if (settle_count < cfg.settle_samples) begin
      settle_count_next = settle_inc;
      if (settle_inc == cfg.settle_samples) begin
        // confirmed press edge steps once and restarts the hold logic
        if (confirmed_level && !level) begin
          fire              = 1'b1;
          hold_count_next   = '0;
          repeat_count_next = '0;
        end
        confirmed_level_next = level;
      end
    end else if (!confirmed_level) begin
      hold_count_next = hold_inc;
      if (hold_inc >= cfg.long_press_ticks) begin
        repeat_count_next = repeat_inc;
        if (repeat_inc >= cfg.repeat_period_ticks) begin
          repeat_count_next = '0;
          fire              = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= 1'b1;
      confirmed_level <= 1'b1;
      settle_count    <= '0;
      hold_count      <= '0;
      repeat_count    <= '0;
    end else if (advance) begin
      previous_sample <= previous_sample_next;
      confirmed_level <= confirmed_level_next;
      settle_count    <= settle_count_next;
      hold_count      <= hold_count_next;
      repeat_count    <= repeat_count_next;
    end
  end

endmodule

FILE: tb/dav_checker.sv
// ---------------------------------------------------------------------------
// dav_checker: result checker for the volume button controller
// Watches the register, scan-tick and result channels, predicts each tick's
// volume result from its own copy of the button state and compares in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module dav_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  dav_pkg::item_t                item,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  dav_pkg::result_t              result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dav_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            outstanding,
  output int                            mismatch_count,
  output int                            checked_count
);
  import dav_pkg::*;

  // register copy
  logic [VOL_W-1:0]    step_amt;
  logic [VOL_W-1:0]    vol_floor;
  logic [VOL_W-1:0]    vol_ceiling;
  logic [SETTLE_W-1:0] settle_need;
  logic [TICK_W-1:0]   long_need;
  logic [TICK_W-1:0]   period_need;

  // per-button state, 0 = up, 1 = down
  logic                raw_prev   [2];
  logic                level_ok   [2];
  logic [SETTLE_W-1:0] settle_cnt [2];
  logic [TICK_W-1:0]   hold_cnt   [2];
  logic [TICK_W-1:0]   rpt_cnt    [2];

  result_t expected_volumes [$];
  int      errors;
  int      checked;

  initial begin
    outstanding    = 0;
    mismatch_count = 0;
    checked_count  = 0;
    errors         = 0;
    checked        = 0;
  end

  function automatic int clamp_step(input int vol, input bit go_up);
    int v;
    v = go_up ? vol + int'(step_amt) : vol - int'(step_amt);
    // ceiling first, so the floor wins when the two cross
    if (v > int'(vol_ceiling)) v = int'(vol_ceiling);
    if (v < int'(vol_floor)) v = int'(vol_floor);
    return v;
  endfunction

  function automatic bit debounce_button(input int b, input logic raw);
    bit fire;
    fire = 1'b0;
    if (raw != raw_prev[b]) begin
      raw_prev[b]   = raw;
      settle_cnt[b] = '0;
    end else if (settle_cnt[b] < settle_need) begin
      settle_cnt[b] = settle_cnt[b] + 1'b1;
      if (settle_cnt[b] == settle_need) begin
        if (level_ok[b] && !raw) begin
          fire        = 1'b1;
          hold_cnt[b] = '0;
          rpt_cnt[b]  = '0;
        end
        level_ok[b] = raw;
      end
    end else if (!level_ok[b]) begin
      if (hold_cnt[b] < long_need) hold_cnt[b] = hold_cnt[b] + 1'b1;
      if (hold_cnt[b] >= long_need) begin
        if (rpt_cnt[b] != TICK_MAX) rpt_cnt[b] = rpt_cnt[b] + 1'b1;
        if (rpt_cnt[b] >= period_need) begin
          rpt_cnt[b] = '0;
          fire       = 1'b1;
        end
      end
    end
    return fire;
  endfunction

  function automatic result_t predict_tick(input item_t t);
    result_t r;
    int      vol;
    bit      up_hit;
    bit      down_hit;
    vol    = int'(t.current_volume);
    up_hit = debounce_button(0, t.up_level);
    if (up_hit) vol = clamp_step(vol, 1'b1);
    // down step works on the volume the up step left
    down_hit = debounce_button(1, t.down_level);
    if (down_hit) vol = clamp_step(vol, 1'b0);
    r.new_volume   = VOL_W'(vol);
    r.volume_write = up_hit | down_hit;
    r.up_fired     = up_hit;
    r.down_fired   = down_hit;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      step_amt    = RST_VOLUME_STEP;
      vol_floor   = RST_VOLUME_FLOOR;
      vol_ceiling = RST_VOLUME_CEILING;
      settle_need = RST_SETTLE_SAMPLES;
      long_need   = RST_LONG_PRESS_TICKS;
      period_need = RST_REPEAT_PERIOD_TICKS;
      for (int b = 0; b < 2; b++) begin
        raw_prev[b]   = 1'b1;
        level_ok[b]   = 1'b1;
        settle_cnt[b] = '0;
        hold_cnt[b]   = '0;
        rpt_cnt[b]    = '0;
      end
      expected_volumes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VOLUME_STEP:         step_amt    = cfg_data[VOL_W-1:0];
          REG_VOLUME_FLOOR:        vol_floor   = cfg_data[VOL_W-1:0];
          REG_VOLUME_CEILING:      vol_ceiling = cfg_data[VOL_W-1:0];
          REG_SETTLE_SAMPLES:      settle_need = cfg_data[SETTLE_W-1:0];
          REG_LONG_PRESS_TICKS:    long_need   = cfg_data[TICK_W-1:0];
          REG_REPEAT_PERIOD_TICKS: period_need = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_volumes.size() == 0) begin
          if (errors < 10)
            $display("%0t: result transaction with nothing expected: vol=%0d wr=%b up=%b dn=%b",
                     $realtime, result.new_volume, result.volume_write,
                     result.up_fired, result.down_fired);
          errors++;
        end else begin
          want = expected_volumes.pop_front();
          checked++;
          if (result.new_volume !== want.new_volume ||
              result.volume_write !== want.volume_write ||
              result.up_fired !== want.up_fired ||
              result.down_fired !== want.down_fired) begin
            if (errors < 10)
              $display("%0t: mismatch exp vol=%0d wr=%b up=%b dn=%b, got vol=%0d wr=%b up=%b dn=%b",
                       $realtime, want.new_volume, want.volume_write, want.up_fired,
                       want.down_fired, result.new_volume, result.volume_write,
                       result.up_fired, result.down_fired);
            errors++;
          end
        end
      end
      if (item_valid && !item_stall) expected_volumes.push_back(predict_tick(item));
    end
    outstanding    <= expected_volumes.size();
    mismatch_count <= errors;
    checked_count  <= checked;
  end

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench top for the volume button controller
// Drives scan ticks with debounced presses, bounces, long holds and register
// changes, with random idle bursts on both sides; the checker judges results.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dav_pkg::*;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                tick_in      = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              tick_out;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;

  int outstanding;
  int mismatch_count;
  int checked_count;

  // current timing settings, used to size the button hold times
  int cur_settle;
  int cur_long;
  int cur_period;
  int settings_count = 0;
  bit bursty = 1'b0;
  bit noisy  = 1'b0;
  int stall_left = 0;

  logic btn_level [2];
  int   btn_left  [2];

  always #2 clk = ~clk;

  debounce_autorepeat_volume i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (tick_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (tick_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dav_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (tick_in),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (tick_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count),
    .checked_count  (checked_count)
  );

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || !bursty) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_tick(input logic up_lvl, input logic down_lvl, input int vol);
    item_t t;
    int    gap;
    t.up_level       = up_lvl;
    t.down_level     = down_lvl;
    t.current_volume = VOL_W'(vol);
    if (bursty && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    tick_in    <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // wait until every tick has its result and the block is quiet
  task automatic drain;
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper data bits are randomized, the block must mask them
  task automatic configure(input int stp, input int flr, input int ceil_v,
                           input int settle, input int lng, input int period);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom);
    write_reg(REG_VOLUME_STEP,         {junk[7], 7'(stp)});
    write_reg(REG_VOLUME_FLOOR,        {junk[6], 7'(flr)});
    write_reg(REG_VOLUME_CEILING,      {junk[5], 7'(ceil_v)});
    write_reg(REG_SETTLE_SAMPLES,      {junk[3:0], 4'(settle)});
    write_reg(REG_LONG_PRESS_TICKS,    8'(lng));
    write_reg(REG_REPEAT_PERIOD_TICKS, 8'(period));
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
    cur_settle = settle;
    cur_long   = lng;
    cur_period = period;
    settings_count++;
  endtask

  // next raw level of one button: taps, held presses, releases, some bounce
  function automatic logic next_level(input int b);
    logic raw;
    if (btn_left[b] <= 0) begin
      btn_level[b] = ~btn_level[b];
      if (btn_level[b]) begin
        btn_left[b] = $urandom_range(1, cur_settle + 6);
      end else begin
        case ($urandom_range(0, 3))
          0:       btn_left[b] = $urandom_range(1, cur_settle + 2);
          1:       btn_left[b] = $urandom_range(1, cur_settle + cur_long + 3);
          default: btn_left[b] = cur_settle + cur_long +
                                 $urandom_range(1, 3) * (cur_period + 1) + $urandom_range(0, 4);
        endcase
      end
    end
    btn_left[b]--;
    raw = btn_level[b];
    if (noisy && $urandom_range(0, 19) == 0) raw = ~raw;
    return raw;
  endfunction

  task automatic run_phase(input int n_items, input bit use_bursts, input bit use_noise);
    int vol;
    bursty = use_bursts;
    noisy  = use_noise;
    for (int i = 0; i < n_items; i++) begin
      vol = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
      send_tick(next_level(0), next_level(1), vol);
    end
    drain();
  endtask

  initial begin
    btn_level[0] = 1'b1;
    btn_level[1] = 1'b1;
    btn_left[0]  = 0;
    btn_left[1]  = 0;
    cur_settle   = RST_SETTLE_SAMPLES;
    cur_long     = RST_LONG_PRESS_TICKS;
    cur_period   = RST_REPEAT_PERIOD_TICKS;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: both buttons confirm together, volume extremes
    repeat (4) send_tick(1'b0, 1'b0, 127);
    repeat (4) send_tick(1'b1, 1'b1, 0);
    drain();
    // floor above ceiling, repeat right away and on every held tick
    configure(127, 100, 0, 1, 0, 0);
    repeat (5) send_tick(1'b0, 1'b0, 64);
    repeat (2) send_tick(1'b1, 1'b1, 100);
    drain();
    // up alone, then settle count dropped to zero while still pressed
    configure(1, 0, 127, 1, 2, 3);
    repeat (2) send_tick(1'b0, 1'b1, 127);
    drain();
    configure(1, 0, 127, 0, 2, 3);
    repeat (6) send_tick(1'b0, 1'b1, 0);
    repeat (2) send_tick(1'b1, 1'b0, 50);
    drain();

    configure(5, 0, 100, 3, 30, 10);
    run_phase(250, 1'b1, 1'b0);
    configure(1, 0, 127, 1, 4, 2);
    run_phase(250, 1'b1, 1'b1);
    configure(127, 0, 127, 15, 0, 0);
    run_phase(150, 1'b0, 1'b0);
    configure(0, 50, 50, 2, 1, 255);
    run_phase(400, 1'b1, 1'b0);
    configure(100, 100, 0, 15, 255, 1);
    run_phase(350, 1'b1, 1'b1);
    repeat (5) begin
      configure($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 15), $urandom_range(0, 40), $urandom_range(0, 20));
      run_phase(100, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
    end
    configure(5, 0, 100, 3, 30, 10);
    run_phase(100, 1'b0, 1'b0);
    repeat (5) @(posedge clk);

    $display("%0d scan-tick results checked over %0d register settings,", checked_count,
             settings_count);
    $display("with taps, bounce, long holds and auto-repeat on both buttons");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
